// ----- src/cra_pkg.sv -----
package cra_pkg;

    localparam int unsigned FRAME_WIDTH_DEF  = 640;
    localparam int unsigned FRAME_HEIGHT_DEF = 480;

    // signed width for clip and rectangle geometry (12-bit inputs plus carry)
    localparam int unsigned CW = 13;

    localparam logic [9:0] CLIP_LEFT_RST   = 10'd0;
    localparam logic [8:0] CLIP_TOP_RST    = 9'd0;
    localparam logic [9:0] CLIP_WIDTH_RST  = 10'd640;
    localparam logic [8:0] CLIP_HEIGHT_RST = 9'd480;

    localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
    localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
    localparam logic [1:0] REG_CLIP_WIDTH  = 2'd2;
    localparam logic [1:0] REG_CLIP_HEIGHT = 2'd3;

    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
    localparam logic [7:0]  ALPHA_CLEAR  = 8'h00;
    localparam logic [7:0]  CHAN_MAX     = 8'd255;
    localparam logic [17:0] ROUND_BIAS   = 18'd127;

    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;
    localparam logic [1:0] CH_LAST  = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RADDR,
        S_RRD,
        S_CLIP,
        S_SETUP,
        S_PFULL,
        S_PRD,
        S_MIX,
        S_PWR,
        S_DONE
    } state_t;

endpackage

// ----- src/cra_if.sv -----
interface cra_cmd_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [11:0] pos_x;
    logic signed [11:0] pos_y;
    logic signed [11:0] rect_width;
    logic signed [11:0] rect_height;
    logic [31:0]        fill_color;

    modport source (output valid, kind, pos_x, pos_y, rect_width, rect_height, fill_color,
                    input ready);
    modport sink (input valid, kind, pos_x, pos_y, rect_width, rect_height, fill_color,
                  output ready);
endinterface

interface cra_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_value;
    logic        outside_frame;

    modport source (output valid, pixel_value, outside_frame, input ready);
    modport sink (input valid, pixel_value, outside_frame, output ready);
endinterface

// ----- src/cra_mix.sv -----
// Shared channel mixer: (s*a + d*(255-a) + 127) / 255.
// A register holds d*255 + (s-d)*a + 127; the divide by 255 works combinationally on it.
module cra_mix
    import cra_pkg::*;
(
    input  logic       clk,
    input  logic       en,
    input  logic [7:0] s,
    input  logic [7:0] d,
    input  logic [7:0] a,
    output logic [7:0] q
);

    logic signed [8:0]  diff;
    logic signed [17:0] prod;
    logic signed [17:0] base;
    logic signed [17:0] sum_next;
    logic [15:0]        sum_reg;
    logic [16:0]        quot;

    assign diff     = $signed({1'b0, s}) - $signed({1'b0, d});
    assign prod     = diff * $signed({1'b0, a});
    assign base     = $signed({2'b00, d, 8'h00}) - $signed({10'h000, d}) + $signed(ROUND_BIAS);
    assign sum_next = base + prod;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg <= sum_next[15:0];
        end
    end

    // exact floor(v/255) for v below 256*255
    assign quot = {1'b0, sum_reg} + {9'h000, sum_reg[15:8]} + 17'd1;
    assign q    = quot[15:8];

endmodule

// ----- src/cra_frame_ram.sv -----
module cra_frame_ram
    import cra_pkg::*;
#(
    parameter int unsigned DEPTH = FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF,
    parameter int unsigned AW    = $clog2(FRAME_WIDTH_DEF * FRAME_HEIGHT_DEF)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/clipped_rect_alpha_fill.sv -----
// Rectangle fill engine with src-over alpha blending into an on-chip ARGB
// framebuffer of FRAME_WIDTH x FRAME_HEIGHT pixels. After reset the engine
// zeroes the framebuffer, one pixel per cycle; cmd.ready stays low
// meanwhile, while clip register writes are taken. A read computes the
// address, reads the framebuffer and returns the pixel; a read outside the
// frame skips it. A fill clips the rectangle and sets up, then writes each
// covered pixel directly at alpha 255, or else per pixel does a framebuffer
// read, four steps through the one shared channel mixer (one per color
// channel plus its divide stage) and a write back. Alpha 0, empty or fully
// clipped rectangles end after setup. Every command returns one item; a new
// command is taken while that item waits on rsp.
module clipped_rect_alpha_fill
    import cra_pkg::*;
#(
    parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
    parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    cra_cmd_if.sink     cmd,
    cra_rsp_if.source   rsp
);

    localparam int unsigned DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [CW-1:0] FW = CW'(FRAME_WIDTH);
    localparam logic signed [CW-1:0] FH = CW'(FRAME_HEIGHT);
    localparam logic [AW-1:0] ROW_STEP  = AW'(FRAME_WIDTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    state_t state_reg, state_next;

    logic [9:0] clip_left_reg, clip_left_next;
    logic [8:0] clip_top_reg, clip_top_next;
    logic [9:0] clip_width_reg, clip_width_next;
    logic [8:0] clip_height_reg, clip_height_next;

    logic               kind_reg, kind_next;
    logic signed [11:0] x_reg, x_next;
    logic signed [11:0] y_reg, y_next;
    logic signed [11:0] w_reg, w_next;
    logic signed [11:0] h_reg, h_next;
    logic [31:0]        color_reg, color_next;

    logic signed [CW-1:0] x0_reg, x0_next;
    logic signed [CW-1:0] x1_reg, x1_next;
    logic signed [CW-1:0] y0_reg, y0_next;
    logic signed [CW-1:0] y1_reg, y1_next;
    logic signed [CW-1:0] px_reg, px_next;
    logic signed [CW-1:0] py_reg, py_next;
    logic                 empty_reg, empty_next;
    logic                 miss_reg, miss_next;

    logic [AW-1:0] addr_reg, addr_next;
    logic [AW-1:0] row_reg, row_next;
    logic [1:0]    ch_reg, ch_next;
    logic [23:0]   mix_res_reg, mix_res_next;

    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_pixel_reg, out_pixel_next;
    logic        out_outside_reg, out_outside_next;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic          mem_re;
    logic [31:0]   mem_rdata;

    logic       mix_en;
    logic [7:0] mix_s;
    logic [7:0] mix_d;
    logic [7:0] mix_q;

    // clip geometry
    logic signed [CW-1:0] cx0, cx1, cy0, cy1;
    logic signed [CW-1:0] clip_r, clip_b;
    logic signed [CW-1:0] rx0, ry0, rx1, ry1;
    logic signed [CW-1:0] px_inc, py_inc;
    logic                 last_col, last_row;
    logic                 cfg_wr;

    cra_frame_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    cra_mix u_mix (
        .clk (clk),
        .en  (mix_en),
        .s   (mix_s),
        .d   (mix_d),
        .a   (color_reg[31:24]),
        .q   (mix_q)
    );

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_CLIP_LEFT:   prdata = {22'h0, clip_left_reg};
            REG_CLIP_TOP:    prdata = {23'h0, clip_top_reg};
            REG_CLIP_WIDTH:  prdata = {22'h0, clip_width_reg};
            REG_CLIP_HEIGHT: prdata = {23'h0, clip_height_reg};
            default:         prdata = 32'h0;
        endcase
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.pixel_value   = out_pixel_reg;
    assign rsp.outside_frame = out_outside_reg;

    // clip window bounded to the frame, intersected with the rectangle
    assign cx0    = $signed({3'b000, clip_left_reg});
    assign cy0    = $signed({4'b0000, clip_top_reg});
    assign clip_r = $signed({2'b00, {1'b0, clip_left_reg} + {1'b0, clip_width_reg}});
    assign clip_b = $signed({3'b000, {1'b0, clip_top_reg} + {1'b0, clip_height_reg}});
    assign cx1    = (clip_r > FW) ? FW : clip_r;
    assign cy1    = (clip_b > FH) ? FH : clip_b;
    assign rx0    = {x_reg[11], x_reg};
    assign ry0    = {y_reg[11], y_reg};
    assign rx1    = rx0 + {w_reg[11], w_reg};
    assign ry1    = ry0 + {h_reg[11], h_reg};

    assign px_inc   = px_reg + CW'(1);
    assign py_inc   = py_reg + CW'(1);
    assign last_col = (px_inc == x1_reg);
    assign last_row = (py_inc == y1_reg);

    always_comb
    begin
        unique case (ch_reg)
            CH_BLUE:
            begin
                mix_s = color_reg[7:0];
                mix_d = mem_rdata[7:0];
            end
            CH_GREEN:
            begin
                mix_s = color_reg[15:8];
                mix_d = mem_rdata[15:8];
            end
            CH_RED:
            begin
                mix_s = color_reg[23:16];
                mix_d = mem_rdata[23:16];
            end
            default:
            begin
                mix_s = color_reg[23:16];
                mix_d = mem_rdata[23:16];
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        clip_left_next   = clip_left_reg;
        clip_top_next    = clip_top_reg;
        clip_width_next  = clip_width_reg;
        clip_height_next = clip_height_reg;
        kind_next        = kind_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        w_next           = w_reg;
        h_next           = h_reg;
        color_next       = color_reg;
        x0_next          = x0_reg;
        x1_next          = x1_reg;
        y0_next          = y0_reg;
        y1_next          = y1_reg;
        px_next          = px_reg;
        py_next          = py_reg;
        empty_next       = empty_reg;
        miss_next        = miss_reg;
        addr_next        = addr_reg;
        row_next         = row_reg;
        ch_next          = ch_reg;
        mix_res_next     = mix_res_reg;
        out_valid_next   = out_valid_reg;
        out_pixel_next   = out_pixel_reg;
        out_outside_next = out_outside_reg;
        mem_we           = 1'b0;
        mem_waddr        = addr_reg;
        mem_wdata        = color_reg;
        mem_re           = 1'b0;
        mix_en           = 1'b0;

        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_CLIP_LEFT:   clip_left_next   = pwdata[9:0];
                REG_CLIP_TOP:    clip_top_next    = pwdata[8:0];
                REG_CLIP_WIDTH:  clip_width_next  = pwdata[9:0];
                REG_CLIP_HEIGHT: clip_height_next = pwdata[8:0];
                default:         clip_left_next   = clip_left_reg;
            endcase
        end

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = 32'h0;
                if (addr_reg == LAST_ADDR)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    addr_next = addr_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    kind_next  = cmd.kind;
                    x_next     = cmd.pos_x;
                    y_next     = cmd.pos_y;
                    w_next     = cmd.rect_width;
                    h_next     = cmd.rect_height;
                    color_next = cmd.fill_color;
                    state_next = (cmd.kind == CMD_READ) ? S_RADDR : S_CLIP;
                end
            end
            S_RADDR:
            begin
                miss_next = x_reg[11] || y_reg[11] || (rx0 >= FW) || (ry0 >= FH);
                addr_next = AW'(y_reg[10:0]) * ROW_STEP + AW'(x_reg[10:0]);
                state_next = (x_reg[11] || y_reg[11] || (rx0 >= FW) || (ry0 >= FH))
                             ? S_DONE : S_RRD;
            end
            S_RRD:
            begin
                mem_re     = 1'b1;
                state_next = S_DONE;
            end
            S_CLIP:
            begin
                x0_next    = (rx0 > cx0) ? rx0 : cx0;
                y0_next    = (ry0 > cy0) ? ry0 : cy0;
                x1_next    = (rx1 < cx1) ? rx1 : cx1;
                y1_next    = (ry1 < cy1) ? ry1 : cy1;
                empty_next = w_reg[11] || (w_reg == 12'sd0) || h_reg[11] || (h_reg == 12'sd0)
                             || (color_reg[31:24] == ALPHA_CLEAR);
                state_next = S_SETUP;
            end
            S_SETUP:
            begin
                if (empty_reg || (x0_reg >= x1_reg) || (y0_reg >= y1_reg))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    addr_next  = AW'(y0_reg[CW-2:0]) * ROW_STEP + AW'(x0_reg[CW-2:0]);
                    row_next   = AW'(y0_reg[CW-2:0]) * ROW_STEP + AW'(x0_reg[CW-2:0]);
                    px_next    = x0_reg;
                    py_next    = y0_reg;
                    state_next = (color_reg[31:24] == ALPHA_OPAQUE) ? S_PFULL : S_PRD;
                end
            end
            S_PRD:
            begin
                mem_re     = 1'b1;
                ch_next    = CH_BLUE;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                mix_en = (ch_reg != CH_LAST);
                // divide stage lags the multiply by one channel
                unique case (ch_reg)
                    CH_GREEN: mix_res_next[7:0]   = mix_q;
                    CH_RED:   mix_res_next[15:8]  = mix_q;
                    CH_LAST:  mix_res_next[23:16] = mix_q;
                    default:  mix_res_next        = mix_res_reg;
                endcase
                if (ch_reg == CH_LAST)
                begin
                    state_next = S_PWR;
                end
                else
                begin
                    ch_next = ch_reg + 2'd1;
                end
            end
            S_PFULL, S_PWR:
            begin
                mem_we    = 1'b1;
                mem_wdata = (state_reg == S_PWR) ? {CHAN_MAX, mix_res_reg} : color_reg;
                if (last_col)
                begin
                    if (last_row)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        py_next    = py_inc;
                        px_next    = x0_reg;
                        row_next   = row_reg + ROW_STEP;
                        addr_next  = row_reg + ROW_STEP;
                        state_next = (state_reg == S_PWR) ? S_PRD : S_PFULL;
                    end
                end
                else
                begin
                    px_next    = px_inc;
                    addr_next  = addr_reg + AW'(1);
                    state_next = (state_reg == S_PWR) ? S_PRD : S_PFULL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next   = 1'b1;
                    out_pixel_next   = (kind_reg == CMD_READ && !miss_reg) ? mem_rdata : 32'h0;
                    out_outside_next = (kind_reg == CMD_READ) && miss_reg;
                    state_next       = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            addr_reg        <= '0;
            out_valid_reg   <= 1'b0;
            clip_left_reg   <= CLIP_LEFT_RST;
            clip_top_reg    <= CLIP_TOP_RST;
            clip_width_reg  <= CLIP_WIDTH_RST;
            clip_height_reg <= CLIP_HEIGHT_RST;
        end
        else
        begin
            state_reg       <= state_next;
            addr_reg        <= addr_next;
            out_valid_reg   <= out_valid_next;
            clip_left_reg   <= clip_left_next;
            clip_top_reg    <= clip_top_next;
            clip_width_reg  <= clip_width_next;
            clip_height_reg <= clip_height_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg        <= kind_next;
        x_reg           <= x_next;
        y_reg           <= y_next;
        w_reg           <= w_next;
        h_reg           <= h_next;
        color_reg       <= color_next;
        x0_reg          <= x0_next;
        x1_reg          <= x1_next;
        y0_reg          <= y0_next;
        y1_reg          <= y1_next;
        px_reg          <= px_next;
        py_reg          <= py_next;
        empty_reg       <= empty_next;
        miss_reg        <= miss_next;
        row_reg         <= row_next;
        ch_reg          <= ch_next;
        mix_res_reg     <= mix_res_next;
        out_pixel_reg   <= out_pixel_next;
        out_outside_reg <= out_outside_next;
    end

endmodule
